// File: rtl/bmie_pkg.sv
// Shared types and codes for the byte machine instruction execute unit.
`timescale 1ns / 1ps

package bmie_pkg;

  // Register file layout
  localparam int unsigned REG_COUNT   = 8;
  localparam logic [2:0]  PC_IDX      = 3'd5;
  localparam logic [2:0]  TOP_IDX     = 3'd7;
  localparam logic [7:0]  TOP_INIT    = 8'hFF;

  // Instruction opcodes
  localparam logic [7:0] ACT_NOP   = 8'd0;
  localparam logic [7:0] ACT_LOAD  = 8'd1;
  localparam logic [7:0] ACT_STORE = 8'd2;
  localparam logic [7:0] ACT_PUSH  = 8'd3;
  localparam logic [7:0] ACT_POP   = 8'd4;
  localparam logic [7:0] ACT_DROP  = 8'd5;
  localparam logic [7:0] ACT_SET   = 8'd6;
  localparam logic [7:0] ACT_SWAP  = 8'd7;
  localparam logic [7:0] ACT_ALU   = 8'd9;
  localparam logic [7:0] ACT_JMP   = 8'd10;
  localparam logic [7:0] ACT_JEQ   = 8'd11;
  localparam logic [7:0] ACT_JNE   = 8'd12;
  localparam logic [7:0] ACT_JGT   = 8'd13;
  localparam logic [7:0] ACT_JLT   = 8'd14;
  localparam logic [7:0] ACT_JZR   = 8'd15;
  localparam logic [7:0] ACT_RET   = 8'd16;

  // ALU operation codes
  localparam logic [7:0] ALU_ADD = 8'd0;
  localparam logic [7:0] ALU_SUB = 8'd1;
  localparam logic [7:0] ALU_INC = 8'd2;
  localparam logic [7:0] ALU_DEC = 8'd3;
  localparam logic [7:0] ALU_MUL = 8'd4;
  localparam logic [7:0] ALU_DIV = 8'd5;
  localparam logic [7:0] ALU_AND = 8'd6;
  localparam logic [7:0] ALU_OR  = 8'd7;
  localparam logic [7:0] ALU_SHL = 8'd8;
  localparam logic [7:0] ALU_SHR = 8'd9;
  localparam logic [7:0] ALU_XOR = 8'd10;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADREG  = 3'd1;
  localparam logic [2:0] ST_BADALU  = 3'd2;
  localparam logic [2:0] ST_DIVZERO = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;
  localparam logic [2:0] ST_UNSUP   = 3'd6;

  typedef struct packed {
    logic [7:0] action;
    logic [7:0] operand_one;
    logic [7:0] operand_two;
    logic [7:0] operand_three;
  } bmie_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] register_value;
    logic [7:0] counter_value;
  } bmie_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_EXEC,
    S_DIV,
    S_WRA,
    S_WRB,
    S_DONE
  } bmie_state_t;

endpackage

// File: rtl/bmie_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bmie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/byte_machine_instruction_execute_unit.sv
// Top level: executes one four-byte instruction against register, data and stack RAMs.
`timescale 1ns / 1ps

//  channel | ports                           | beat
//  --------+---------------------------------+-------------------------------------
//  input   | in_valid, in_stall, in_data     | one instruction (action, 3 operands)
//  output  | out_valid, out_stall, out_data  | status, register a, program counter
//
//  One instruction at a time: a beat is taken in IDLE, then two register reads
//  (RDA, RDB), the execute state EXEC, the write state WRA (then WRB for swap)
//  and the result state DONE; a divide runs the 8-step restoring divider in
//  DIV between EXEC and WRA. Synchronous active-low reset clears control,
//  register and memory valid bits; no clearing pass. A stalled result waits in
//  the output register while the next instruction runs; that instruction holds
//  in DONE until the output register drains.

module byte_machine_instruction_execute_unit
  import bmie_pkg::*;
#(
  parameter int MEMORY_DEPTH = 256,
  parameter int STACK_DEPTH  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  bmie_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output bmie_out_t out_data
);

  localparam int AW = $clog2(MEMORY_DEPTH);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);

  // Control and state registers
  bmie_state_t state_r, state_nxt;
  bmie_in_t    ins_r;
  logic [7:0]  ra_r, rb_r, pc_r;
  logic [REG_COUNT-1:0]    rf_vld_r;
  logic [MEMORY_DEPTH-1:0] dm_vld_r;
  logic [LW-1:0]           lvl_r;

  // Pending write plan from the execute cycle
  logic [2:0] stat_r;
  logic       w1_en_r, w2_en_r, dm_we_r, push_r, pop_r;
  logic [2:0] w1_idx_r;
  logic [7:0] w1_val_r;

  // Divider
  logic [7:0] div_rem_r, div_quo_r;
  logic [2:0] div_cnt_r;
  logic [8:0] div_tmp;
  logic       div_bit;
  logic [7:0] div_rem_nxt, div_quo_nxt;

  // Output register
  logic      out_valid_r;
  bmie_out_t out_data_r;
  logic      out_ld;

  // RAM ports
  logic          rf_we;
  logic [2:0]    rf_waddr, rf_raddr;
  logic [7:0]    rf_wdata, rf_rdata;
  logic          dm_we;
  logic [AW-1:0] dm_addr;
  logic [7:0]    dm_rdata;
  logic          stk_we;
  logic [SW-1:0] stk_waddr, stk_raddr;
  logic [LW-1:0] lvl_dec;
  logic [7:0]    stk_rdata;

  // Execute cycle signals
  logic [7:0]  a_op, b_op, c_op;
  logic [7:0]  ra_now, rb_now;
  logic        need1, need2, unsup, badreg, b_in_range, lvl_full, lvl_empty;
  logic [15:0] prod;
  logic [2:0]  ex_stat;
  logic        ex_w1_en, ex_w2_en, ex_dm_we, ex_push, ex_pop, ex_div;
  logic [2:0]  ex_w1_idx;
  logic [7:0]  ex_w1_val;
  logic [7:0]  reg_out;

  assign a_op = ins_r.operand_one;
  assign b_op = ins_r.operand_two;
  assign c_op = ins_r.operand_three;

  assign dm_addr   = b_op[AW-1:0];
  assign lvl_dec   = lvl_r - LW'(1);
  assign stk_raddr = lvl_dec[SW-1:0];
  assign stk_waddr = lvl_r[SW-1:0];

  bmie_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_reg_ram (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  bmie_ram #(.WIDTH(8), .DEPTH(MEMORY_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_addr),
    .wdata (ra_r),
    .raddr (dm_addr),
    .rdata (dm_rdata)
  );

  bmie_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (ra_r),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RDA;
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_EXEC;
      S_EXEC: state_nxt = ex_div ? S_DIV : S_WRA;
      S_DIV:  if (div_cnt_r == 3'd7) state_nxt = S_WRA;
      S_WRA:  state_nxt = w2_en_r ? S_WRB : S_DONE;
      S_WRB:  state_nxt = S_DONE;
      S_DONE: if (out_ld) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State-driven outputs: handshake and RAM control
  always_comb begin
    in_stall = 1'b1;
    rf_raddr = b_op[2:0];
    rf_we    = 1'b0;
    rf_waddr = w1_idx_r;
    rf_wdata = w1_val_r;
    dm_we    = 1'b0;
    stk_we   = 1'b0;
    out_ld   = 1'b0;
    unique case (state_r)
      S_IDLE: in_stall = 1'b0;
      S_RDA:  rf_raddr = a_op[2:0];
      S_WRA: begin
        rf_we  = w1_en_r;
        dm_we  = dm_we_r;
        stk_we = push_r;
      end
      S_WRB: begin
        rf_we    = 1'b1;
        rf_waddr = b_op[2:0];
        rf_wdata = ra_r;
      end
      S_DONE: out_ld = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // Operand values with reset defaults for never-written registers
  always_comb begin
    ra_now = rf_vld_r[a_op[2:0]] ? rf_rdata : ((a_op[2:0] == TOP_IDX) ? TOP_INIT : 8'h00);
    rb_now = rf_vld_r[b_op[2:0]] ? rf_rdata : ((b_op[2:0] == TOP_IDX) ? TOP_INIT : 8'h00);
  end

  assign prod       = ra_r * rb_now;
  assign b_in_range = {1'b0, b_op} < 9'(MEMORY_DEPTH);
  assign lvl_full   = lvl_r == LW'(STACK_DEPTH);
  assign lvl_empty  = lvl_r == '0;

  // Decode operand use
  always_comb begin
    need1 = 1'b0;
    need2 = 1'b0;
    unsup = 1'b0;
    unique case (ins_r.action)
      ACT_LOAD, ACT_STORE, ACT_PUSH, ACT_POP, ACT_SET, ACT_JZR: need1 = 1'b1;
      ACT_SWAP, ACT_ALU, ACT_JEQ, ACT_JNE, ACT_JGT, ACT_JLT: begin
        need1 = 1'b1;
        need2 = 1'b1;
      end
      ACT_NOP, ACT_DROP, ACT_JMP, ACT_RET: ;
      default: unsup = 1'b1;
    endcase
    badreg = (need1 && a_op >= 8'(REG_COUNT)) || (need2 && b_op >= 8'(REG_COUNT));
  end

  // Execute: status and write plan
  always_comb begin
    ex_stat   = ST_OK;
    ex_w1_en  = 1'b0;
    ex_w1_idx = a_op[2:0];
    ex_w1_val = 8'h00;
    ex_w2_en  = 1'b0;
    ex_dm_we  = 1'b0;
    ex_push   = 1'b0;
    ex_pop    = 1'b0;
    ex_div    = 1'b0;
    if (unsup) begin
      ex_stat = ST_UNSUP;
    end else if (badreg) begin
      ex_stat = ST_BADREG;
    end else begin
      unique case (ins_r.action)
        ACT_LOAD: begin
          ex_w1_en  = 1'b1;
          ex_w1_val = (b_in_range && dm_vld_r[dm_addr]) ? dm_rdata : 8'h00;
        end
        ACT_STORE: ex_dm_we = b_in_range;
        ACT_PUSH: begin
          if (lvl_full) ex_stat = ST_FULL;
          else ex_push = 1'b1;
        end
        ACT_POP: begin
          if (lvl_empty) begin
            ex_stat = ST_EMPTY;
          end else begin
            ex_pop    = 1'b1;
            ex_w1_en  = 1'b1;
            ex_w1_val = stk_rdata;
          end
        end
        ACT_DROP: begin
          if (lvl_empty) ex_stat = ST_EMPTY;
          else ex_pop = 1'b1;
        end
        ACT_SET: begin
          ex_w1_en  = 1'b1;
          ex_w1_val = b_op;
        end
        ACT_SWAP: begin
          ex_w1_en  = 1'b1;
          ex_w1_val = rb_now;
          ex_w2_en  = 1'b1;
        end
        ACT_ALU: begin
          ex_w1_en = 1'b1;
          unique case (c_op)
            ALU_ADD: ex_w1_val = ra_r + rb_now;
            ALU_SUB: ex_w1_val = ra_r - rb_now;
            ALU_INC: ex_w1_val = ra_r + 8'd1;
            ALU_DEC: ex_w1_val = ra_r - 8'd1;
            ALU_MUL: ex_w1_val = prod[7:0];
            ALU_DIV: begin
              if (rb_now == 8'h00) begin
                ex_stat  = ST_DIVZERO;
                ex_w1_en = 1'b0;
              end else begin
                ex_div = 1'b1;
              end
            end
            ALU_AND: ex_w1_val = ra_r & rb_now;
            ALU_OR:  ex_w1_val = ra_r | rb_now;
            ALU_SHL: ex_w1_val = (rb_now >= 8'd8) ? 8'h00 : (ra_r << rb_now[2:0]);
            ALU_SHR: ex_w1_val = (rb_now >= 8'd8) ? 8'h00 : (ra_r >> rb_now[2:0]);
            ALU_XOR: ex_w1_val = ra_r ^ rb_now;
            default: begin
              ex_stat  = ST_BADALU;
              ex_w1_en = 1'b0;
            end
          endcase
        end
        ACT_JMP: begin
          ex_w1_en  = 1'b1;
          ex_w1_idx = PC_IDX;
          ex_w1_val = pc_r + a_op;
        end
        ACT_JEQ, ACT_JNE, ACT_JGT, ACT_JLT: begin
          ex_w1_idx = PC_IDX;
          ex_w1_val = pc_r + c_op;
          unique case (ins_r.action)
            ACT_JEQ: ex_w1_en = ra_r == rb_now;
            ACT_JNE: ex_w1_en = ra_r != rb_now;
            ACT_JGT: ex_w1_en = ra_r > rb_now;
            default: ex_w1_en = ra_r < rb_now;
          endcase
        end
        ACT_JZR: begin
          ex_w1_idx = PC_IDX;
          ex_w1_val = pc_r + b_op;
          ex_w1_en  = ra_r == 8'h00;
        end
        default: ;
      endcase
    end
  end

  // One restoring divide step
  always_comb begin
    div_tmp     = {div_rem_r, div_quo_r[7]};
    div_bit     = div_tmp >= {1'b0, rb_r};
    div_rem_nxt = div_bit ? 8'(div_tmp - {1'b0, rb_r}) : div_tmp[7:0];
    div_quo_nxt = {div_quo_r[6:0], div_bit};
  end

  // Final value of register a for the result beat
  always_comb begin
    if (a_op >= 8'(REG_COUNT)) reg_out = 8'h00;
    else if (w2_en_r && b_op[2:0] == a_op[2:0]) reg_out = ra_r;
    else if (w1_en_r && w1_idx_r == a_op[2:0]) reg_out = w1_val_r;
    else reg_out = ra_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rf_vld_r    <= '0;
      dm_vld_r    <= '0;
      lvl_r       <= '0;
      pc_r        <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (rf_we) begin
        rf_vld_r[rf_waddr] <= 1'b1;
        if (rf_waddr == PC_IDX) pc_r <= rf_wdata;
      end
      if (dm_we) dm_vld_r[dm_addr] <= 1'b1;
      if (state_r == S_WRA) begin
        if (push_r) lvl_r <= lvl_r + LW'(1);
        else if (pop_r) lvl_r <= lvl_dec;
      end
      out_valid_r <= out_ld || (out_valid_r && out_stall);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) ins_r <= in_data;
    if (state_r == S_RDB) ra_r <= ra_now;
    if (state_r == S_EXEC) begin
      rb_r      <= rb_now;
      stat_r    <= ex_stat;
      w1_en_r   <= ex_w1_en;
      w1_idx_r  <= ex_w1_idx;
      w1_val_r  <= ex_w1_val;
      w2_en_r   <= ex_w2_en;
      dm_we_r   <= ex_dm_we;
      push_r    <= ex_push;
      pop_r     <= ex_pop;
      div_rem_r <= 8'h00;
      div_quo_r <= ra_r;
      div_cnt_r <= 3'd0;
    end
    if (state_r == S_DIV) begin
      div_rem_r <= div_rem_nxt;
      div_quo_r <= div_quo_nxt;
      div_cnt_r <= div_cnt_r + 3'd1;
      if (div_cnt_r == 3'd7) w1_val_r <= div_quo_nxt;
    end
    if (out_ld) begin
      out_data_r.status         <= stat_r;
      out_data_r.register_value <= reg_out;
      out_data_r.counter_value  <= pc_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
